[rtl/spdu_pkg.sv]
// ----------------------------------------------------------------------------
// spdu_pkg
// Shared types and constants of the stream pattern deletion unit.
// ----------------------------------------------------------------------------
package spdu_pkg;

    localparam int PAT_MAX_DEF = 8;
    localparam int WORD_W      = 32;
    localparam int PAIR_W      = 64;
    localparam int NUM_PAIRS   = 4;
    localparam int LEN_W       = 4;
    localparam int CFG_IDX_W   = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAIR_0      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAIR_1      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAIR_2      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PAIR_3      = 3'd4;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              end_in;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] out_value;
        logic              has_value;
        logic              end_of_list;
        logic              run_last;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;      // take the input word into the pending buffer
        logic push;      // move the oldest pending word into the hold stage
        logic hit;       // pending words are a pattern prefix
        logic fin_hold;  // send the hold stage as the final result
        logic fin_bare;  // send a bare end marker
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic cnt_zero;
        logic match;
        logic hold_valid;
        logic out_free;
        logic end_flag;
    } t_dp_sts;

endpackage

[rtl/spdu_ctrl.sv]
// ----------------------------------------------------------------------------
// spdu_ctrl
// Sequencer: accepts one request, scans the pending buffer, flushes, finishes.
// ----------------------------------------------------------------------------
module spdu_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  spdu_pkg::t_dp_sts i_sts,
    output spdu_pkg::t_dp_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FLUSH  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       can_push;

    // hold stage may take a word if empty or if it drains into the output now
    assign can_push = !i_sts.hold_valid || i_sts.out_free;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_sts.cnt_zero) begin
                    n_state = i_sts.end_flag ? ST_FLUSH : ST_FINISH;
                end else if (i_sts.match) begin
                    o_cmd.hit = 1'b1;
                    n_state   = i_sts.end_flag ? ST_FLUSH : ST_FINISH;
                end else if (can_push) begin
                    o_cmd.push = 1'b1;
                end
            end
            ST_FLUSH: begin
                if (i_sts.cnt_zero) begin
                    n_state = ST_FINISH;
                end else if (can_push) begin
                    o_cmd.push = 1'b1;
                end
            end
            ST_FINISH: begin
                if (i_sts.hold_valid) begin
                    if (i_sts.out_free) begin
                        o_cmd.fin_hold = 1'b1;
                        n_state        = ST_IDLE;
                    end
                end else if (i_sts.end_flag) begin
                    if (i_sts.out_free) begin
                        o_cmd.fin_bare = 1'b1;
                        n_state        = ST_IDLE;
                    end
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/spdu_datapath.sv]
// ----------------------------------------------------------------------------
// spdu_datapath
// Pattern registers, pending shift buffer, prefix compare, hold and output stage.
// ----------------------------------------------------------------------------
module spdu_datapath #(
    parameter int PAT_MAX = spdu_pkg::PAT_MAX_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [spdu_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [spdu_pkg::PAIR_W-1:0]    i_cfg_data,
    input  spdu_pkg::t_in_item             i_in_data,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output spdu_pkg::t_out_item            o_out_data,
    input  spdu_pkg::t_dp_cmd              i_cmd,
    output spdu_pkg::t_dp_sts              o_sts
);

    localparam int CW = $clog2(PAT_MAX + 1);

    logic [spdu_pkg::LEN_W-1:0]  r_pat_len;
    logic [spdu_pkg::PAIR_W-1:0] r_pat_pair [spdu_pkg::NUM_PAIRS];
    logic [spdu_pkg::WORD_W-1:0] r_pend     [PAT_MAX];
    logic [CW-1:0]               r_count;
    logic                        r_end;
    logic                        r_hold_valid;
    logic [spdu_pkg::WORD_W-1:0] r_hold_data;
    logic                        r_out_valid;
    spdu_pkg::t_out_item         r_out_data;

    logic [spdu_pkg::LEN_W-1:0]  len_eff;
    logic [spdu_pkg::LEN_W-1:0]  count_ext;
    logic [CW-1:0]               load_idx;
    logic [PAT_MAX-1:0]          word_ok;
    logic                        out_free;
    logic                        hold_to_out;

    // clamp the length to the buffer depth
    assign len_eff   = (r_pat_len > spdu_pkg::LEN_W'(PAT_MAX))
                     ? spdu_pkg::LEN_W'(PAT_MAX) : r_pat_len;
    assign count_ext = spdu_pkg::LEN_W'(r_count);
    assign load_idx  = (r_count >= CW'(PAT_MAX)) ? CW'(PAT_MAX - 1) : r_count;

    // entries at or above the fill count do not take part in the compare
    always_comb begin
        for (int i = 0; i < PAT_MAX; i++) begin
            word_ok[i] = (CW'(i) >= r_count) ||
                         (r_pend[i] == r_pat_pair[i / 2][(i % 2) * spdu_pkg::WORD_W +:
                                                          spdu_pkg::WORD_W]);
        end
    end

    assign out_free    = !r_out_valid || i_out_ready;
    assign hold_to_out = i_cmd.push && r_hold_valid;

    assign o_sts.cnt_zero   = (r_count == '0);
    assign o_sts.match      = (count_ext <= len_eff) && (&word_ok);
    assign o_sts.hold_valid = r_hold_valid;
    assign o_sts.out_free   = out_free;
    assign o_sts.end_flag   = r_end;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_len    <= '0;
            for (int p = 0; p < spdu_pkg::NUM_PAIRS; p++) begin
                r_pat_pair[p] <= '0;
            end
            r_count      <= '0;
            r_end        <= 1'b0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_idx)
                    spdu_pkg::CFG_PATTERN_LEN: begin
                        r_pat_len <= i_cfg_data[spdu_pkg::LEN_W-1:0];
                    end
                    spdu_pkg::CFG_PAIR_0: r_pat_pair[0] <= i_cfg_data;
                    spdu_pkg::CFG_PAIR_1: r_pat_pair[1] <= i_cfg_data;
                    spdu_pkg::CFG_PAIR_2: r_pat_pair[2] <= i_cfg_data;
                    spdu_pkg::CFG_PAIR_3: r_pat_pair[3] <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (i_cmd.load) begin
                r_count <= load_idx + CW'(1);
                r_end   <= i_in_data.end_in;
            end else if (i_cmd.push) begin
                r_count <= r_count - CW'(1);
            end else if (i_cmd.hit && (count_ext == len_eff)) begin
                r_count <= '0;
            end

            if (i_cmd.push) begin
                r_hold_valid <= 1'b1;
            end else if (i_cmd.fin_hold) begin
                r_hold_valid <= 1'b0;
            end

            if (hold_to_out || i_cmd.fin_hold || i_cmd.fin_bare) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int i = 0; i < PAT_MAX; i++) begin
                if (CW'(i) == load_idx) begin
                    r_pend[i] <= i_in_data.value;
                end
            end
        end else if (i_cmd.push) begin
            for (int i = 0; i < PAT_MAX - 1; i++) begin
                r_pend[i] <= r_pend[i + 1];
            end
        end

        if (i_cmd.push) begin
            r_hold_data <= r_pend[0];
        end

        if (hold_to_out) begin
            r_out_data <= '{out_value: r_hold_data, has_value: 1'b1,
                            end_of_list: 1'b0, run_last: 1'b0};
        end else if (i_cmd.fin_hold) begin
            r_out_data <= '{out_value: r_hold_data, has_value: 1'b1,
                            end_of_list: r_end, run_last: 1'b1};
        end else if (i_cmd.fin_bare) begin
            r_out_data <= '{out_value: '0, has_value: 1'b0,
                            end_of_list: 1'b1, run_last: 1'b1};
        end
    end

endmodule

[rtl/stream_pattern_deletion_unit.sv]
// ----------------------------------------------------------------------------
// stream_pattern_deletion_unit
// Deletes every occurrence of a configured word pattern from a list stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one list word
//   per request, with end_in set on the final word of a list. Output channel
//   (o_out_valid / i_out_ready / o_out_data) carries the kept words in order;
//   run_last marks the last result caused by one input request, end_of_list
//   the result that closes a list (a bare marker with has_value low if the
//   final word left nothing to send).
//   Configuration: write pattern_len (index 0) and the four pattern word
//   pairs (indexes 1 to 4) through i_cfg_wr_en / i_cfg_idx / i_cfg_data while
//   the block is idle.
// Timing:
//   One request at a time: the input is ready only while idle, so a request
//   is scanned, flushed at end of list and finished before the next one is
//   accepted. A kept word passes the pending buffer, the hold stage and the
//   output register, in that order.
// Reset zeroes the pending fill count, the pattern registers and both stages.
// When the receiver stalls, the output register holds its result and the
// sequencer waits in front of a full hold stage; nothing is dropped.
// ----------------------------------------------------------------------------
module stream_pattern_deletion_unit #(
    parameter int PAT_MAX = spdu_pkg::PAT_MAX_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [spdu_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [spdu_pkg::PAIR_W-1:0]    i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  spdu_pkg::t_in_item             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output spdu_pkg::t_out_item            o_out_data
);

    spdu_pkg::t_dp_cmd cmd;
    spdu_pkg::t_dp_sts sts;

    // sequencer: accept, scan alignments, flush at end of list, finish
    spdu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // pending buffer, compare, hold stage and output register
    spdu_datapath #(
        .PAT_MAX (PAT_MAX)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

[rtl/spdu_checker.sv]
// ----------------------------------------------------------------------------
// spdu_checker
// Port-level checks of the stream pattern deletion unit, bound to the top.
// ----------------------------------------------------------------------------
module spdu_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input spdu_pkg::t_out_item o_out_data
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    // one request at a time: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after accept");

    // the closing result is the last of its request
    a_eol_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.end_of_list) |-> o_out_data.run_last)
        else $error("end of list without run_last");

    // a result without a word is a bare end marker
    a_bare_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.has_value) |->
            (o_out_data.end_of_list && (o_out_data.out_value == '0)))
        else $error("empty result that is not an end marker");

endmodule

bind stream_pattern_deletion_unit spdu_checker u_spdu_checker (.*);

[sim/spdu_deletion_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spdu_deletion_checker
// Watches the configuration port and both list channels of the pattern
// deletion unit, predicts the kept words of every request and compares each
// result that leaves the block against the oldest prediction.
// ----------------------------------------------------------------------------
module spdu_deletion_checker #(
    parameter int PAT_MAX = spdu_pkg::PAT_MAX_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [spdu_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [spdu_pkg::PAIR_W-1:0]    i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  spdu_pkg::t_in_item             i_in_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  spdu_pkg::t_out_item            i_out_data,
    output int                             o_fail_count,
    output int                             o_outstanding,
    output int                             o_results_checked,
    output int                             o_kept_words,
    output int                             o_bare_markers
);

    localparam int REPORT_LINES = 40;
    localparam int PAIR_IDX_W   = $clog2(spdu_pkg::NUM_PAIRS);

    logic [spdu_pkg::LEN_W-1:0]  pat_len;
    logic [spdu_pkg::PAIR_W-1:0] pat_pairs [spdu_pkg::NUM_PAIRS];
    logic [spdu_pkg::WORD_W-1:0] held_words [PAT_MAX];
    int                          held_count = 0;
    spdu_pkg::t_out_item         kept_expected [$];

    int fail_count      = 0;
    int outstanding     = 0;
    int results_checked = 0;
    int kept_words      = 0;
    int bare_markers    = 0;

    assign o_fail_count      = fail_count;
    assign o_outstanding     = outstanding;
    assign o_results_checked = results_checked;
    assign o_kept_words      = kept_words;
    assign o_bare_markers    = bare_markers;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (fail_count < REPORT_LINES)
            $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        fail_count++;
    endtask

    function automatic logic [spdu_pkg::WORD_W-1:0] pattern_word(input int k);
        logic [spdu_pkg::PAIR_W-1:0] pair;
        pair = pat_pairs[k / 2];
        return (k % 2 != 0) ? pair[spdu_pkg::PAIR_W-1:spdu_pkg::WORD_W]
                            : pair[spdu_pkg::WORD_W-1:0];
    endfunction

    function automatic bit held_is_prefix(input int n);
        int i;
        for (i = 0; i < n; i++)
            if (held_words[i] != pattern_word(i))
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic spdu_pkg::t_out_item kept_result(
        input logic [spdu_pkg::WORD_W-1:0] word, input logic has);
        kept_result           = '0;
        kept_result.out_value = word;
        kept_result.has_value = has;
    endfunction

    // Append the request to the held words, then send the oldest one until
    // what stays held is a prefix of the pattern; drop a full match, flush at end of list.
    task automatic predict_kept_words(input spdu_pkg::t_in_item req);
        spdu_pkg::t_out_item batch [PAT_MAX];
        int                  n;
        int                  eff_len;
        int                  i;
        n       = 0;
        eff_len = (pat_len > PAT_MAX) ? PAT_MAX : int'(pat_len);
        if (held_count > PAT_MAX - 1)
            held_count = PAT_MAX - 1;
        held_words[held_count] = req.value;
        held_count++;
        while (held_count > 0) begin
            if (held_count <= eff_len && held_is_prefix(held_count)) begin
                if (held_count == eff_len)
                    held_count = 0;
                break;
            end
            if (n < PAT_MAX) begin
                batch[n] = kept_result(held_words[0], 1'b1);
                n++;
            end
            for (i = 1; i < held_count; i++)
                held_words[i-1] = held_words[i];
            held_count--;
        end
        if (req.end_in) begin
            for (i = 0; i < held_count && n < PAT_MAX; i++) begin
                batch[n] = kept_result(held_words[i], 1'b1);
                n++;
            end
            held_count = 0;
            if (n == 0) begin
                batch[0] = kept_result('0, 1'b0);
                n        = 1;
            end
            batch[n-1].end_of_list = 1'b1;
        end
        if (n > 0)
            batch[n-1].run_last = 1'b1;
        for (i = 0; i < n; i++)
            kept_expected.push_back(batch[i]);
    endtask

    task automatic check_result(input spdu_pkg::t_out_item got);
        spdu_pkg::t_out_item want;
        if (kept_expected.size() == 0) begin
            report_mismatch("result with no request behind it", 64'(got.out_value), '0);
            return;
        end
        want = kept_expected.pop_front();
        results_checked++;
        if (want.has_value)
            kept_words++;
        else
            bare_markers++;
        if (got.out_value != want.out_value)
            report_mismatch("out_value", 64'(got.out_value), 64'(want.out_value));
        if (got.has_value != want.has_value)
            report_mismatch("has_value", 64'(got.has_value), 64'(want.has_value));
        if (got.end_of_list != want.end_of_list)
            report_mismatch("end_of_list", 64'(got.end_of_list), 64'(want.end_of_list));
        if (got.run_last != want.run_last)
            report_mismatch("run_last", 64'(got.run_last), 64'(want.run_last));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pat_len    = '0;
            pat_pairs  = '{default: '0};
            held_count = 0;
            kept_expected.delete();
        end else begin
            if (i_out_valid && i_out_ready)
                check_result(i_out_data);
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    spdu_pkg::CFG_PATTERN_LEN: pat_len = i_cfg_data[spdu_pkg::LEN_W-1:0];
                    spdu_pkg::CFG_PAIR_0, spdu_pkg::CFG_PAIR_1,
                    spdu_pkg::CFG_PAIR_2, spdu_pkg::CFG_PAIR_3:
                        pat_pairs[PAIR_IDX_W'(i_cfg_idx - spdu_pkg::CFG_PAIR_0)] = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                predict_kept_words(i_in_data);
        end
        outstanding = kept_expected.size();
    end

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Regression of the stream pattern deletion unit. A directed opening covers
// pass-through, bare end markers, the oversized length, the widest burst of
// results and a length cut under held words; random lists built from pattern
// occurrences, prefixes, broken copies and noise follow under changing
// patterns, with random gaps on both channels. The checker predicts and
// compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb;

    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 12;
    localparam int RANDOM_REQUESTS = 150;
    localparam int MAX_WAIT        = 10;
    localparam int SETTLE_CYCLES   = 24;
    localparam int LIMIT_CYCLES    = 400000;
    localparam int LEN_RAW_MAX     = (1 << spdu_pkg::LEN_W) - 1;
    localparam int PAT_N           = spdu_pkg::PAT_MAX_DEF;

    // highest index the port can carry; it decodes to no register
    localparam logic [spdu_pkg::CFG_IDX_W-1:0] CFG_IDX_TOP = '1;

    localparam logic [spdu_pkg::WORD_W-1:0] WORD_ZERO = '0;
    localparam logic [spdu_pkg::WORD_W-1:0] WORD_ONES = '1;
    localparam logic [spdu_pkg::WORD_W-1:0] WORD_ODD  = 32'h5A5A_A5A5;

    typedef enum int {SEG_MATCH, SEG_PREFIX, SEG_BROKEN, SEG_NOISE} t_segment;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [spdu_pkg::CFG_IDX_W-1:0] cfg_idx   = '0;
    logic [spdu_pkg::PAIR_W-1:0]    cfg_data  = '0;
    logic                           in_valid  = 1'b0;
    logic                           in_ready;
    spdu_pkg::t_in_item             in_data   = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    spdu_pkg::t_out_item            out_data;

    int fail_count;
    int outstanding;
    int results_checked;
    int kept_words;
    int bare_markers;

    // pattern as last written, kept here to build matching lists
    logic [spdu_pkg::WORD_W-1:0] cur_pattern [PAT_N];
    int                          cur_len = 0;

    int requests_sent    = 0;
    int lists_sent       = 0;
    int settings_written = 0;
    int cycle_count      = 0;
    int in_gap           = 0;
    int in_calm          = 0;

    stream_pattern_deletion_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    spdu_deletion_checker i_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_wr_en       (cfg_wr_en),
        .i_cfg_idx         (cfg_idx),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_in_data         (in_data),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_out_data        (out_data),
        .o_fail_count      (fail_count),
        .o_outstanding     (outstanding),
        .o_results_checked (results_checked),
        .o_kept_words      (kept_words),
        .o_bare_markers    (bare_markers)
    );

    initial begin
        forever #CLK_HALF clk = ~clk;
    end

    // Draw the idle cycles in front of the next request or result. Now and
    // then start a calm stretch with no idling at all.
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            calm = $urandom_range(8, 32);
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic int pattern_span();
        return (cur_len > PAT_N) ? PAT_N : cur_len;
    endfunction

    function automatic logic [spdu_pkg::WORD_W-1:0] noise_word();
        case ($urandom_range(0, 5))
            0:       return WORD_ZERO;
            1:       return WORD_ONES;
            2, 3:    return cur_pattern[$urandom_range(0, PAT_N - 1)];
            default: return $urandom();
        endcase
    endfunction

    // Everything below runs just after a rising edge and drives with
    // nonblocking assignments, so the block samples settled inputs.

    // Present one request and hold it until accepted. Keep valid high when
    // the next request follows without a gap; lower it otherwise.
    task automatic send_request(input logic [spdu_pkg::WORD_W-1:0] word, input logic last);
        spdu_pkg::t_in_item req;
        req.value  = word;
        req.end_in = last;
        if (in_gap > 0)
            repeat (in_gap) @(posedge clk);
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (!in_ready);
        requests_sent++;
        if (last)
            lists_sent++;
        in_gap = draw_wait(in_calm);
        if (in_gap > 0)
            in_valid <= 1'b0;
    endtask

    // Drop valid if it was left up for a back-to-back request.
    task automatic stop_requests();
        if (in_gap == 0)
            in_valid <= 1'b0;
        in_gap = 1;
    endtask

    // Wait for every predicted result, then let a held request finish its scan.
    task automatic drain();
        do @(negedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [spdu_pkg::CFG_IDX_W-1:0] idx,
                             input logic [spdu_pkg::PAIR_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_idx   <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Write the length and all four pairs from cur_len and cur_pattern;
    // optionally poke an index that decodes to nothing first.
    task automatic program_pattern(input bit poke_spare);
        logic [spdu_pkg::PAIR_W-1:0] data;
        int                          p;
        if (poke_spare)
            cfg_write(spdu_pkg::CFG_IDX_W'($urandom_range(spdu_pkg::CFG_PAIR_3 + 1,
                                                          CFG_IDX_TOP)),
                      {$urandom(), $urandom()});
        // random upper bits around the 4-bit length field
        data                           = {$urandom(), $urandom()};
        data[spdu_pkg::LEN_W-1:0]      = spdu_pkg::LEN_W'(cur_len);
        cfg_write(spdu_pkg::CFG_PATTERN_LEN, data);
        for (p = 0; p < spdu_pkg::NUM_PAIRS; p++)
            cfg_write(spdu_pkg::CFG_PAIR_0 + spdu_pkg::CFG_IDX_W'(p),
                      {cur_pattern[2*p+1], cur_pattern[2*p]});
        cfg_wr_en <= 1'b0;
        settings_written++;
    endtask

    // Pick a length with weight on the extremes, and either fully random
    // words or words from two symbols so shifted alignments match again.
    task automatic choose_pattern();
        logic [spdu_pkg::WORD_W-1:0] sym_a;
        logic [spdu_pkg::WORD_W-1:0] sym_b;
        bit                          few_symbols;
        int                          k;
        case ($urandom_range(0, 5))
            0:       cur_len = 0;
            1:       cur_len = 1;
            2:       cur_len = PAT_N;
            3:       cur_len = $urandom_range(PAT_N + 1, LEN_RAW_MAX);
            default: cur_len = $urandom_range(2, PAT_N - 1);
        endcase
        few_symbols = $urandom_range(0, 1);
        sym_a       = $urandom();
        sym_b       = $urandom();
        for (k = 0; k < PAT_N; k++) begin
            if (few_symbols)
                cur_pattern[k] = ($urandom_range(0, 2) == 0) ? sym_b : sym_a;
            else
                cur_pattern[k] = $urandom();
        end
        program_pattern($urandom_range(0, 3) == 0);
    endtask

    // Build one list from segments (whole occurrences, prefixes, copies
    // with one word spoiled, noise) and send it; close it on request.
    task automatic send_list(input int segments, input bit close);
        logic [spdu_pkg::WORD_W-1:0] words [$];
        t_segment                    kind;
        int                          span;
        int                          s;
        int                          k;
        int                          cut;
        int                          pos;
        int                          pick;
        span = pattern_span();
        for (s = 0; s < segments; s++) begin
            pick = $urandom_range(0, 19);
            if (span == 0 || pick >= 15)
                kind = SEG_NOISE;
            else if (pick < 7)
                kind = SEG_MATCH;
            else if (pick < 11)
                kind = SEG_PREFIX;
            else
                kind = SEG_BROKEN;
            case (kind)
                SEG_MATCH: begin
                    for (k = 0; k < span; k++)
                        words.push_back(cur_pattern[k]);
                end
                SEG_PREFIX: begin
                    cut = (span > 1) ? $urandom_range(1, span - 1) : 1;
                    for (k = 0; k < cut; k++)
                        words.push_back(cur_pattern[k]);
                end
                SEG_BROKEN: begin
                    pos = $urandom_range(0, span - 1);
                    for (k = 0; k < span; k++)
                        words.push_back((k == pos) ? noise_word() : cur_pattern[k]);
                end
                default: begin
                    cut = $urandom_range(1, 3);
                    for (k = 0; k < cut; k++)
                        words.push_back(noise_word());
                end
            endcase
        end
        for (k = 0; k < words.size(); k++)
            send_request(words[k], close && (k == words.size() - 1));
    endtask

    // Receiver: stall a random number of cycles before each result.
    initial begin : receiver
        int stall;
        int calm;
        calm = 0;
        forever begin
            stall = draw_wait(calm);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Give up if the run hangs.
    initial begin : watchdog
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still due", cycle_count, outstanding);
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        int k;
        int base;
        int lists;
        int l;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Length zero: write every register, poke a dead index, pass a word.
        for (k = 0; k < PAT_N; k++)
            cur_pattern[k] = $urandom();
        cur_len = 0;
        program_pattern(1'b1);
        send_request(WORD_ONES, 1'b1);
        stop_requests();
        drain();

        // One-word pattern of zero: a lone match leaves a bare end marker,
        // and a match at the tail of a list still closes it.
        for (k = 0; k < PAT_N; k++)
            cur_pattern[k] = WORD_ZERO;
        cur_len = 1;
        program_pattern(1'b1);
        send_request(WORD_ZERO, 1'b1);
        send_request(WORD_ONES, 1'b0);
        send_request(WORD_ZERO, 1'b1);
        stop_requests();
        drain();

        // Length fifteen acts as eight: seven zeros, then the odd word.
        cur_pattern[PAT_N - 1] = WORD_ODD;
        cur_len                = LEN_RAW_MAX;
        program_pattern(1'b0);
        // Eight zeros: the oldest falls out, the rest plus the tail match.
        repeat (PAT_N) send_request(WORD_ZERO, 1'b0);
        send_request(WORD_ODD, 1'b1);
        // A full prefix spoiled by the final word sends eight results for one request.
        repeat (PAT_N - 1) send_request(WORD_ZERO, 1'b0);
        send_request(WORD_ONES, 1'b1);
        stop_requests();
        drain();

        // Hold three zeros, cut the length to two, then end the list: the
        // held words no longer fit and go out oldest first.
        repeat (3) send_request(WORD_ZERO, 1'b0);
        stop_requests();
        drain();
        cur_len = 2;
        program_pattern(1'b0);
        send_request(WORD_ODD, 1'b1);
        stop_requests();
        drain();

        // Random phases: new pattern, a few lists; sometimes leave the last
        // list open so the next pattern meets held words.
        base = requests_sent;
        while (requests_sent - base < RANDOM_REQUESTS) begin
            choose_pattern();
            lists = $urandom_range(1, 3);
            for (l = 0; l < lists; l++)
                send_list($urandom_range(1, 5), (l < lists - 1) || ($urandom_range(0, 3) != 0));
            stop_requests();
            drain();
        end
        // close whatever list the last phase left open
        send_request(noise_word(), 1'b1);
        stop_requests();
        drain();

        @(negedge clk);
        $display("Sent %0d requests in %0d lists under %0d pattern settings.",
                 requests_sent, lists_sent, settings_written);
        $display("Checked %0d results: %0d kept words, %0d bare end markers.",
                 results_checked, kept_words, bare_markers);
        if (fail_count == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[files.f]
rtl/spdu_pkg.sv
rtl/spdu_ctrl.sv
rtl/spdu_datapath.sv
rtl/stream_pattern_deletion_unit.sv
rtl/spdu_checker.sv
sim/spdu_deletion_checker.sv
sim/tb.sv
